// ----- src/edtm_pkg.sv -----
package edtm_pkg;

    localparam int MAX_QUERY = 32;
    localparam int IDX_W     = $clog2(MAX_QUERY);
    localparam int LEN_W     = $clog2(MAX_QUERY + 1);

    localparam logic [7:0] SAT_MAX = 8'd255;

    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_WORD   = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_PUSH
    } t_state;

    function automatic logic [7:0] sat_inc(input logic [7:0] v);
        return (v == SAT_MAX) ? v : v + 8'd1;
    endfunction

    function automatic logic [7:0] min8(input logic [7:0] a, input logic [7:0] b);
        return (a < b) ? a : b;
    endfunction

endpackage

// ----- src/edit_distance_threshold_match_top.sv -----
// Query appends and clears do not stall the input. A candidate character is
// handled by a read-modify-write walk over the cost row memory, one entry per
// cycle and one entry per query character (a query holds up to 32 characters).
// The character that ends a word then loads the output register in S_PUSH, which waits while a held result is stalled.
// Reset (synchronous, active low) empties the query, rewinds the row at once
// through per-entry valid bits and sets max_distance to 0; no clearing pass.
module edit_distance_threshold_match_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_data,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [1:0] i_op,
    input  logic [7:0] i_ch,
    input  logic       i_last,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_distance,
    output logic       o_within_limit,
    output logic       o_query_truncated
);

    localparam int IW = edtm_pkg::IDX_W;
    localparam int LW = edtm_pkg::LEN_W;

    edtm_pkg::t_state r_state, n_state;

    logic [7:0]    r_qmem [edtm_pkg::MAX_QUERY];
    logic [7:0]    r_cmem [edtm_pkg::MAX_QUERY];
    logic [edtm_pkg::MAX_QUERY-1:0] r_vld;

    logic [7:0]    r_q_rd, r_c_rd;
    logic          r_c_rd_vld;

    logic [IW-1:0] r_idx, n_idx;
    logic [7:0]    r_diag, n_diag;
    logic [7:0]    r_left, n_left;
    logic [LW-1:0] r_qlen, n_qlen;
    logic          r_ovf, n_ovf;
    logic [7:0]    r_wpos, n_wpos;
    logic [7:0]    r_res, n_res;
    logic [7:0]    r_ch, n_ch;
    logic          r_last, n_last;
    logic [7:0]    r_maxd;

    logic          r_out_valid;
    logic [7:0]    r_out_dist;
    logic          r_out_within;
    logic          r_out_trunc;

    logic          acc;
    logic          rd_en;
    logic [IW-1:0] rd_addr;
    logic          q_we;
    logic          c_we;
    logic          rewind;
    logic          out_load;
    logic [7:0]    up;
    logic [7:0]    sub;
    logic [7:0]    best;
    logic [7:0]    wnext;

    assign acc        = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != edtm_pkg::S_IDLE);

    // cell update for the entry whose read data is arriving
    always_comb begin
        up    = r_c_rd_vld ? r_c_rd : edtm_pkg::sat_inc(8'(r_idx));
        sub   = (r_q_rd == r_ch) ? r_diag : edtm_pkg::sat_inc(r_diag);
        best  = edtm_pkg::min8(edtm_pkg::min8(edtm_pkg::sat_inc(up),
                                              edtm_pkg::sat_inc(r_left)), sub);
        wnext = edtm_pkg::sat_inc(r_wpos);
    end

    always_comb begin
        n_state  = r_state;
        n_idx    = r_idx;
        n_diag   = r_diag;
        n_left   = r_left;
        n_qlen   = r_qlen;
        n_ovf    = r_ovf;
        n_wpos   = r_wpos;
        n_res    = r_res;
        n_ch     = r_ch;
        n_last   = r_last;
        rd_en    = 1'b0;
        rd_addr  = r_idx + IW'(1);
        q_we     = 1'b0;
        c_we     = 1'b0;
        rewind   = 1'b0;
        out_load = 1'b0;
        unique case (r_state)
            edtm_pkg::S_IDLE: begin
                if (acc) begin
                    n_ch   = i_ch;
                    n_last = i_last;
                    unique case (i_op)
                        edtm_pkg::OP_CLEAR: begin
                            n_qlen = '0;
                            n_ovf  = 1'b0;
                            rewind = 1'b1;
                        end
                        edtm_pkg::OP_APPEND: begin
                            if (r_qlen < LW'(edtm_pkg::MAX_QUERY)) begin
                                q_we   = 1'b1;
                                n_qlen = r_qlen + LW'(1);
                            end else begin
                                n_ovf = 1'b1;
                            end
                            rewind = 1'b1;
                        end
                        edtm_pkg::OP_WORD: begin
                            if (r_qlen == '0) begin
                                if (i_last) begin
                                    n_res   = wnext;
                                    rewind  = 1'b1;
                                    n_state = edtm_pkg::S_PUSH;
                                end else begin
                                    n_wpos = wnext;
                                end
                            end else begin
                                rd_en   = 1'b1;
                                rd_addr = '0;
                                n_idx   = '0;
                                n_diag  = r_wpos;
                                n_left  = wnext;
                                n_state = edtm_pkg::S_RUN;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            edtm_pkg::S_RUN: begin
                c_we   = 1'b1;
                n_diag = up;
                n_left = best;
                if (LW'(r_idx) + LW'(1) == r_qlen) begin
                    if (r_last) begin
                        n_res   = best;
                        rewind  = 1'b1;
                        n_state = edtm_pkg::S_PUSH;
                    end else begin
                        n_wpos  = wnext;
                        n_state = edtm_pkg::S_IDLE;
                    end
                end else begin
                    rd_en = 1'b1;
                    n_idx = r_idx + IW'(1);
                end
            end
            edtm_pkg::S_PUSH: begin
                if (!r_out_valid || !i_out_stall) begin
                    out_load = 1'b1;
                    n_state  = edtm_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = edtm_pkg::S_IDLE;
            end
        endcase
        if (rewind) begin
            n_wpos = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= edtm_pkg::S_IDLE;
            r_qlen  <= '0;
            r_ovf   <= 1'b0;
            r_wpos  <= '0;
            r_maxd  <= '0;
        end else begin
            r_state <= n_state;
            r_qlen  <= n_qlen;
            r_ovf   <= n_ovf;
            r_wpos  <= n_wpos;
            if (i_cfg_we) begin
                r_maxd <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_diag <= n_diag;
        r_left <= n_left;
        r_res  <= n_res;
        r_ch   <= n_ch;
        r_last <= n_last;
    end

    always_ff @(posedge i_clk) begin
        if (q_we) begin
            r_qmem[r_qlen[IW-1:0]] <= i_ch;
        end
        if (rd_en) begin
            r_q_rd <= r_qmem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_we) begin
            r_cmem[r_idx] <= best;
        end
        if (rd_en) begin
            r_c_rd <= r_cmem[rd_addr];
        end
    end

    // rewind drops every entry back to its reset value
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld      <= '0;
            r_c_rd_vld <= 1'b0;
        end else begin
            if (rewind) begin
                r_vld <= '0;
            end else if (c_we) begin
                r_vld[r_idx] <= 1'b1;
            end
            if (rd_en) begin
                r_c_rd_vld <= r_vld[rd_addr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_dist   <= r_res;
            r_out_within <= (r_res <= r_maxd);
            r_out_trunc  <= r_ovf;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_distance        = r_out_dist;
    assign o_within_limit    = r_out_within;
    assign o_query_truncated = r_out_trunc;

    a_out_from_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state) == edtm_pkg::S_PUSH)
        else $error("result transfer without a finished word");

    a_idx_in_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == edtm_pkg::S_RUN |-> LW'(r_idx) < r_qlen)
        else $error("row walk past query length");

    a_qlen_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_qlen <= LW'(edtm_pkg::MAX_QUERY))
        else $error("query length over capacity");

    a_run_keeps_qlen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == edtm_pkg::S_RUN |=> $stable(r_qlen))
        else $error("query changed during row walk");

endmodule
